// ----- src/dmm_pkg.sv -----
`default_nettype none

package dmm_pkg;

    // fixed field widths
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 3;
    localparam int FIELD_ELEM_W = 32;
    localparam int SUM_W      = 64;
    localparam int DIGIT_W    = 8;

    // input tdata layout, lowest bit first
    localparam int IN_ROW_LSB  = 0;
    localparam int IN_COL_LSB  = IN_ROW_LSB + IDX_W;
    localparam int IN_ELEM_LSB = IN_COL_LSB + IDX_W;
    localparam int IN_SUM_LSB  = IN_ELEM_LSB + FIELD_ELEM_W;
    localparam int IN_DATA_W   = 104;

    // output tdata layout, lowest bit first
    localparam int OUT_ROW_LSB = 0;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + IDX_W;
    localparam int OUT_SUM_LSB = OUT_COL_LSB + IDX_W;
    localparam int OUT_DATA_W  = 72;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_LEN = 2'd1,
        CFG_COLS_B    = 2'd2,
        CFG_NONE      = 2'd3
    } cfg_index_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_LOAD_C = 2'd2,
        CMD_START  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic first;
    } dmm_mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic sat;
    } dmm_mac_stat_t;

endpackage

`default_nettype wire

// ----- src/dmm_ram.sv -----
`default_nettype none

module dmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/dmm_mac.sv -----
`default_nettype none

// digit-serial signed multiply, then one saturating add into the accumulator
module dmm_mac
    import dmm_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire dmm_mac_cmd_t                 cmd,
    input  wire logic signed [ELEM_WIDTH-1:0] a,
    input  wire logic signed [ELEM_WIDTH-1:0] b,
    input  wire logic        [SUM_W-1:0]      init_value,
    output dmm_mac_stat_t                     stat,
    output logic             [SUM_W-1:0]      acc
);

    localparam int NDIG  = (ELEM_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int BW    = NDIG * DIGIT_W;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic                    running_reg;
    logic                    add_pend_reg;
    logic [CNT_W-1:0]        dig_cnt_reg;
    logic signed [SUM_W-1:0] a_sh_reg;
    logic [BW-1:0]           b_sh_reg;
    logic [SUM_W-1:0]        prod_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic                    sat_reg;

    logic                    top_digit;
    logic signed [DIGIT_W:0] digit;
    logic signed [SUM_W+DIGIT_W:0] pp;
    logic [SUM_W-1:0]        sum;
    logic                    ovf;
    logic [SUM_W-1:0]        acc_next;

    always_comb begin
        top_digit = dig_cnt_reg == CNT_W'(NDIG - 1);
        // the top digit carries the sign weight
        digit = top_digit ? {b_sh_reg[DIGIT_W-1], b_sh_reg[DIGIT_W-1:0]}
                          : {1'b0, b_sh_reg[DIGIT_W-1:0]};
        pp  = a_sh_reg * digit;
        sum = acc_reg + prod_reg;
        ovf = (acc_reg[SUM_W-1] == prod_reg[SUM_W-1]) && (sum[SUM_W-1] != acc_reg[SUM_W-1]);
        if (ovf) begin
            acc_next = acc_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            acc_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            add_pend_reg <= 1'b0;
            dig_cnt_reg  <= '0;
            sat_reg      <= 1'b0;
        end else begin
            if (cmd.start) begin
                running_reg <= 1'b1;
                dig_cnt_reg <= '0;
                if (cmd.first) begin
                    sat_reg <= 1'b0;
                end
            end else if (running_reg) begin
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
                if (top_digit) begin
                    running_reg  <= 1'b0;
                    add_pend_reg <= 1'b1;
                end
            end else if (add_pend_reg) begin
                add_pend_reg <= 1'b0;
                sat_reg      <= sat_reg | ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            a_sh_reg <= SUM_W'(a);
            b_sh_reg <= BW'(b);
            prod_reg <= '0;
            if (cmd.first) begin
                acc_reg <= init_value;
            end
        end else if (running_reg) begin
            prod_reg <= prod_reg + pp[SUM_W-1:0];
            a_sh_reg <= a_sh_reg <<< DIGIT_W;
            b_sh_reg <= b_sh_reg >> DIGIT_W;
        end else if (add_pend_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = running_reg | add_pend_reg;
    assign stat.sat  = sat_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

// ----- src/dense_matrix_multiply_core.sv -----
`default_nettype none

// channel   | dir | handshake         | payload
// ----------+-----+-------------------+------------------------------------------
// s_        | in  | s_tvalid/s_tready | tuser: command; tdata: row, col, element,
//           |     |                   |   initial_sum
// m_        | out | m_tvalid/m_tready | tdata: out_row, out_col, sum; tuser:
//           |     |                   |   saturated; tlast: last entry of the run
// cfg_      | in  | cfg_wr_en         | cfg_index, cfg_wdata (rows_a, inner_len,
//           |     |                   |   cols_b)
//
// load transfers are accepted whenever the sequencer is idle
// a start runs every C entry in row-major order; each product steps through
//   fetch, operand load, NDIG digit steps, saturating add and a hand-back,
//   with NDIG = ceil(ELEM_WIDTH / 8)
// one entry runs one product per inner index, then the emit
// the sequencer stalls in emit while the output register is held by m_tready low
// reset clears control state and the C valid bits; no clearing pass is needed
module dense_matrix_multiply_core
    import dmm_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row[2:0], col[5:3], element[37:6],
                                                  // initial_sum[101:38], zero fill
    input  wire logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // out_row[2:0], out_col[5:3],
                                                  // sum[69:6], zero fill
    output logic                       m_tuser,   // saturated
    output logic                       m_tlast,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM);

    // last index in use for a dimension register, with out-of-range values clamped
    function automatic logic [DIM_W-1:0] last_idx(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM - 1);
        end else begin
            return DIM_W'(int'(v) - 1);
        end
    endfunction

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    logic [DIM_W-1:0] r_reg, c_reg, k_reg;
    logic [DIM_W-1:0] nr_last, nk_last, nc_last;
    logic             last_k, last_c, last_entry;

    logic [DEPTH-1:0] c_valid_reg;
    logic             c_hit_reg;

    logic                  m_tvalid_reg;
    logic [IDX_W-1:0]      out_row_reg, out_col_reg;
    logic [SUM_W-1:0]      out_sum_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;

    // input fields
    command_t           in_cmd;
    logic [IDX_W-1:0]   in_row, in_col;
    logic [ADDR_W-1:0]  in_addr;
    logic               in_range;
    logic               in_fire;

    // sequencer controls
    logic               slot_free;
    logic               emit_fire;
    logic               mul_done;
    logic [ADDR_W-1:0]  a_raddr, b_raddr, c_raddr;
    logic               we_a, we_b, we_c;

    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
    logic [SUM_W-1:0]      c_rdata;
    logic [SUM_W-1:0]      mac_init;
    logic [SUM_W-1:0]      mac_acc;
    dmm_mac_cmd_t          mac_cmd;
    dmm_mac_stat_t         mac_stat;

    always_comb begin
        in_cmd   = command_t'(s_tuser);
        in_row   = s_tdata[IN_ROW_LSB +: IDX_W];
        in_col   = s_tdata[IN_COL_LSB +: IDX_W];
        in_addr  = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
        in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

        nr_last    = last_idx(rows_a_reg);
        nk_last    = last_idx(inner_len_reg);
        nc_last    = last_idx(cols_b_reg);
        last_k     = k_reg == nk_last;
        last_c     = c_reg == nc_last;
        last_entry = last_c && (r_reg == nr_last);

        a_raddr = ADDR_W'(int'(r_reg) * MAX_DIM + int'(k_reg));
        b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(c_reg));
        c_raddr = ADDR_W'(int'(r_reg) * MAX_DIM + int'(c_reg));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_cmd == CMD_START) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL: begin
                if (!mac_stat.busy) begin
                    state_next = last_k ? ST_EMIT : ST_FETCH;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = last_entry ? ST_IDLE : ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready      = state_reg == ST_IDLE;
        in_fire       = s_tvalid && s_tready;
        we_a          = in_fire && in_range && in_cmd == CMD_LOAD_A;
        we_b          = in_fire && in_range && in_cmd == CMD_LOAD_B;
        we_c          = in_fire && in_range && in_cmd == CMD_LOAD_C;
        slot_free     = !m_tvalid_reg || m_tready;
        mac_cmd.start = state_reg == ST_LOAD;
        mac_cmd.first = k_reg == '0;
        // a C entry never loaded since the last run reads as zero
        mac_init      = c_hit_reg ? c_rdata : '0;
        mul_done      = state_reg == ST_MUL && !mac_stat.busy;
        emit_fire     = state_reg == ST_EMIT && slot_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_a_reg    <= CFG_RESET;
            inner_len_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            c_valid_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                    CFG_INNER_LEN: inner_len_reg <= cfg_wdata;
                    CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                    CFG_NONE:      ;
                    default:       ;
                endcase
            end

            // entry walk: k innermost, then columns, then rows
            if (in_fire && in_cmd == CMD_START) begin
                r_reg <= '0;
                c_reg <= '0;
                k_reg <= '0;
            end else if (mul_done && !last_k) begin
                k_reg <= k_reg + 1'b1;
            end else if (emit_fire) begin
                k_reg <= '0;
                if (last_c) begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end

            // the C store empties after each run
            if (emit_fire && last_entry) begin
                c_valid_reg <= '0;
            end else if (we_c) begin
                c_valid_reg[in_addr] <= 1'b1;
            end

            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        c_hit_reg <= c_valid_reg[c_raddr];
        if (emit_fire) begin
            out_row_reg  <= IDX_W'(r_reg);
            out_col_reg  <= IDX_W'(c_reg);
            out_sum_reg  <= mac_acc;
            out_sat_reg  <= mac_stat.sat;
            out_last_reg <= last_entry;
        end
    end

    dmm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (aclk),
        .we    (we_a),
        .waddr (in_addr),
        .wdata (s_tdata[IN_ELEM_LSB +: ELEM_WIDTH]),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (aclk),
        .we    (we_b),
        .waddr (in_addr),
        .wdata (s_tdata[IN_ELEM_LSB +: ELEM_WIDTH]),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dmm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram_c (
        .clk   (aclk),
        .we    (we_c),
        .waddr (in_addr),
        .wdata (s_tdata[IN_SUM_LSB +: SUM_W]),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    dmm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (mac_cmd),
        .a          (a_rdata),
        .b          (b_rdata),
        .init_value (mac_init),
        .stat       (mac_stat),
        .acc        (mac_acc)
    );

    always_comb begin
        m_tvalid = m_tvalid_reg;
        m_tdata  = '0;
        m_tdata[OUT_ROW_LSB +: IDX_W] = out_row_reg;
        m_tdata[OUT_COL_LSB +: IDX_W] = out_col_reg;
        m_tdata[OUT_SUM_LSB +: SUM_W] = out_sum_reg;
        m_tuser  = out_sat_reg;
        m_tlast  = out_last_reg;
    end

endmodule

`default_nettype wire
